/* sv/mav2fc_pkg.sv */
`default_nettype none

package mav2fc_pkg;

  // Frame geometry
  localparam int unsigned MaxFrameBytes = 512;
  localparam int unsigned PosW          = $clog2(MaxFrameBytes + 1);
  localparam int unsigned CmpW          = 11;
  localparam int unsigned MinFrameBytes = 12;
  localparam int unsigned HeaderBytes   = 10;

  // Front-to-back queue
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // APB register map
  localparam int unsigned AddrW        = 3;
  localparam int unsigned DataW        = 32;
  localparam logic        RegStartMark = 1'b0;
  localparam logic [7:0]  StartMarkRst = 8'd253;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusTooShort = 3'd1,
    StatusTrunc    = 3'd2,
    StatusUnknown  = 3'd3,
    StatusCrcBad   = 3'd4
  } status_e;

  // What the back end does with one word
  typedef enum logic [2:0] {
    KindSkip,
    KindStart,
    KindCrc,
    KindExtra,
    KindRxHi
  } kind_e;

  typedef struct packed {
    logic [7:0]      data;
    kind_e           kind;
    logic            is_len;
    logic            id_en;
    logic [1:0]      id_idx;
    logic            last;
    logic [PosW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic       known;
    logic [7:0] extra;
    logic [7:0] min_len;
  } id_info_t;

  function automatic id_info_t id_lookup(input logic [23:0] id);
    id_info_t r;
    r = '0;
    r.known = 1'b1;
    case (id)
      24'd0:   begin r.extra = 8'd50;  r.min_len = 8'd9;  end
      24'd30:  begin r.extra = 8'd39;  r.min_len = 8'd28; end
      24'd31:  begin r.extra = 8'd246; r.min_len = 8'd32; end
      24'd32:  begin r.extra = 8'd185; r.min_len = 8'd28; end
      24'd33:  begin r.extra = 8'd104; r.min_len = 8'd28; end
      24'd85:  begin r.extra = 8'd140; r.min_len = 8'd51; end
      default: r = '0;
    endcase
    return r;
  endfunction

  // CRC-16/MCRF4XX, one byte
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

`default_nettype wire

/* sv/mav2fc_if.sv */
`default_nettype none

interface mav2fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mav2fc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] msg_id;
  logic [7:0]  payload_len;
  logic        start_ok;
  logic        size_ok;

  modport source (output valid, output status, output msg_id, output payload_len,
                  output start_ok, output size_ok, input ready);
  modport sink (input valid, input status, input msg_id, input payload_len,
                input start_ok, input size_ok, output ready);
endinterface

`default_nettype wire

/* sv/mav2fc_front.sv */
`default_nettype none

module mav2fc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  mav2fc_in_if.sink                in_i,
  input  wire logic                full_i,
  output logic                     push_o,
  output mav2fc_pkg::entry_t       entry_o
);

  logic [mav2fc_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]                  len_q, len_d;
  logic [mav2fc_pkg::CmpW-1:0] p_ext, crc_pos;
  logic [7:0]                  len_eff;
  logic                        in_range;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    p_ext    = mav2fc_pkg::CmpW'(pos_q);
    in_range = pos_q < mav2fc_pkg::PosW'(mav2fc_pkg::MaxFrameBytes);
    len_eff  = (pos_q == mav2fc_pkg::PosW'(1)) ? in_i.data_byte : len_q;
    crc_pos  = mav2fc_pkg::CmpW'(mav2fc_pkg::HeaderBytes) + mav2fc_pkg::CmpW'(len_eff);

    entry_o        = '0;
    entry_o.data   = in_i.data_byte;
    entry_o.last   = in_i.last_byte;
    entry_o.kind   = mav2fc_pkg::KindSkip;
    entry_o.is_len = in_range && (pos_q == mav2fc_pkg::PosW'(1));
    entry_o.id_en  = in_range && (p_ext >= 11'd7) && (p_ext <= 11'd9);
    entry_o.id_idx = 2'(p_ext - 11'd7);
    entry_o.count  = in_range ? pos_q + mav2fc_pkg::PosW'(1) : pos_q;

    if (in_range) begin
      if (pos_q == '0) begin
        entry_o.kind = mav2fc_pkg::KindStart;
      end else if (p_ext < crc_pos) begin
        entry_o.kind = mav2fc_pkg::KindCrc;
      end else if (p_ext == crc_pos) begin
        entry_o.kind = mav2fc_pkg::KindExtra;
      end else if (p_ext == crc_pos + 11'd1) begin
        entry_o.kind = mav2fc_pkg::KindRxHi;
      end
    end

    pos_d = pos_q;
    len_d = len_q;
    if (push_o) begin
      if (in_i.last_byte) begin
        pos_d = '0;
        len_d = '0;
      end else begin
        pos_d = entry_o.count;
        if (entry_o.is_len) begin
          len_d = in_i.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

/* sv/mav2fc_queue.sv */
`default_nettype none

module mav2fc_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire mav2fc_pkg::entry_t  entry_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output mav2fc_pkg::entry_t       entry_o
);

  mav2fc_pkg::entry_t               mem_q [mav2fc_pkg::QueueDepth];
  logic [mav2fc_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [mav2fc_pkg::QCntW-1:0]     cnt_q;

  assign full_o  = cnt_q == mav2fc_pkg::QCntW'(mav2fc_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == mav2fc_pkg::QPtrW'(mav2fc_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == mav2fc_pkg::QPtrW'(mav2fc_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/mav2fc_back.sv */
`default_nettype none

module mav2fc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          start_marker_i,
  input  wire logic                valid_i,
  input  wire mav2fc_pkg::entry_t  entry_i,
  output logic                     pop_o,
  mav2fc_out_if.source             out_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic [23:0] id_q, id_d;
  logic [15:0] rx_q, rx_d;
  logic        first_q, first_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [23:0] id_out_q;
  logic [7:0]  len_out_q;
  logic        start_ok_q, size_ok_q;

  mav2fc_pkg::id_info_t        cur_info, fin_info;
  mav2fc_pkg::status_e         status;
  logic [mav2fc_pkg::CmpW-1:0] n_ext, need;
  logic                        size_ok;

  assign pop_o = valid_i && (!entry_i.last || !out_valid_q || out_o.ready);

  always_comb begin
    crc_d    = crc_q;
    len_d    = len_q;
    id_d     = id_q;
    rx_d     = rx_q;
    first_d  = first_q;
    cur_info = mav2fc_pkg::id_lookup(id_q);

    unique case (entry_i.kind)
      mav2fc_pkg::KindStart: first_d = entry_i.data == start_marker_i;
      mav2fc_pkg::KindCrc: begin
        crc_d = mav2fc_pkg::crc_add(crc_q, entry_i.data);
        if (entry_i.is_len) begin
          len_d = entry_i.data;
        end
        if (entry_i.id_en) begin
          case (entry_i.id_idx)
            2'd0:    id_d[7:0]   = entry_i.data;
            2'd1:    id_d[15:8]  = entry_i.data;
            default: id_d[23:16] = entry_i.data;
          endcase
        end
      end
      mav2fc_pkg::KindExtra: begin
        if (cur_info.known) begin
          crc_d = mav2fc_pkg::crc_add(crc_q, cur_info.extra);
        end
        rx_d = {8'h00, entry_i.data};
      end
      mav2fc_pkg::KindRxHi: rx_d = {entry_i.data, rx_q[7:0]};
      default: ;
    endcase

    // Final verdict, first failing check wins
    fin_info = mav2fc_pkg::id_lookup(id_d);
    n_ext    = mav2fc_pkg::CmpW'(entry_i.count);
    need     = mav2fc_pkg::CmpW'(mav2fc_pkg::MinFrameBytes) + mav2fc_pkg::CmpW'(len_d);
    if (n_ext < mav2fc_pkg::CmpW'(mav2fc_pkg::MinFrameBytes)) begin
      status = mav2fc_pkg::StatusTooShort;
    end else if (n_ext < need) begin
      status = mav2fc_pkg::StatusTrunc;
    end else if (!fin_info.known) begin
      status = mav2fc_pkg::StatusUnknown;
    end else if (crc_d != rx_d) begin
      status = mav2fc_pkg::StatusCrcBad;
    end else begin
      status = mav2fc_pkg::StatusOk;
    end
    size_ok = fin_info.known && (len_d >= fin_info.min_len) && (n_ext >= need) &&
              (n_ext >= mav2fc_pkg::CmpW'(mav2fc_pkg::MinFrameBytes));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= 16'hFFFF;
      len_q       <= '0;
      id_q        <= '0;
      rx_q        <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && entry_i.last) begin
        crc_q       <= 16'hFFFF;
        len_q       <= '0;
        id_q        <= '0;
        rx_q        <= '0;
        first_q     <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (pop_o) begin
          crc_q   <= crc_d;
          len_q   <= len_d;
          id_q    <= id_d;
          rx_q    <= rx_d;
          first_q <= first_d;
        end
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.last) begin
      status_q   <= status;
      id_out_q   <= id_d;
      len_out_q  <= len_d;
      start_ok_q <= first_d;
      size_ok_q  <= size_ok;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.msg_id      = id_out_q;
  assign out_o.payload_len = len_out_q;
  assign out_o.start_ok    = start_ok_q;
  assign out_o.size_ok     = size_ok_q;

endmodule

`default_nettype wire

/* sv/mavlink2_frame_checker.sv */
// Channel   Dir  Payload                                                Words
// in_i      in   data_byte[7:0], last_byte                              one per frame byte
// out_o     out  status[2:0], msg_id[23:0], payload_len[7:0],           one per frame
//                start_ok, size_ok
// APB       in   start_marker at byte address 0                         config
//
// Throughput is one byte per cycle while the queue has room: the front end
// classifies a byte from its own position and length counters, the back end
// folds it into the CRC through a two-entry queue. The verdict loads into an
// output register at the edge that pops the last byte from the queue. A stalled
// output only holds up the back end at the next last byte, so the front keeps
// taking bytes until the queue fills. Reset clears all frame state.
`default_nettype none

module mavlink2_frame_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mav2fc_in_if.sink                           in_i,
  mav2fc_out_if.source                        out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mav2fc_pkg::AddrW-1:0]   paddr,
  input  wire logic [mav2fc_pkg::DataW-1:0]   pwdata,
  output logic      [mav2fc_pkg::DataW-1:0]   prdata,
  output logic                                pready
);

  logic [7:0]         start_marker_q;
  logic               push, full, q_valid, pop;
  mav2fc_pkg::entry_t push_entry, head_entry;

  // Config register: single word, written on the APB access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mav2fc_pkg::RegStartMark) ?
                  mav2fc_pkg::DataW'(start_marker_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= mav2fc_pkg::StartMarkRst;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mav2fc_pkg::RegStartMark) begin
      start_marker_q <= pwdata[7:0];
    end
  end

  // Front: count positions and tag each byte
  mav2fc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decouple front and back so each can stall on its own
  mav2fc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  // Back: run the CRC, capture fields, issue the verdict
  mav2fc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_marker_i (start_marker_q),
    .valid_i        (q_valid),
    .entry_i        (head_entry),
    .pop_o          (pop),
    .out_o          (out_o)
  );

endmodule

`default_nettype wire
